// ----- src/tsenv_pkg.sv -----
`timescale 1ns / 1ps
// tsenv_pkg: shared types, widths and codes of the tension spline envelope table
// used by the channel interfaces and the top level

package tsenv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UW   = FRAC_BITS + 1;      // x, y, phase, level
  localparam int TW   = FRAC_BITS + 2;      // tension, signed differences
  localparam int SW   = FRAC_BITS + 4;      // tension scale 2*one - ta - tb
  localparam int MTW  = FRAC_BITS + 3;      // tangents
  localparam int AW   = FRAC_BITS + 5;      // cubic coefficient
  localparam int BW   = FRAC_BITS + 6;      // square coefficient
  localparam int TQW  = FRAC_BITS + 8;      // segment parameter t
  localparam int UUW  = FRAC_BITS + 12;     // first horner value
  localparam int VW   = FRAC_BITS + 7;      // second horner value after clamp
  localparam int MAW  = UUW;                // multiplier operand a
  localparam int MBW  = TQW;                // multiplier operand b
  localparam int PW   = MAW + MBW;          // product
  localparam int SHW  = PW - FRAC_BITS;     // product after the fraction shift
  localparam int QW   = 2 * FRAC_BITS + 1;  // dividend / quotient
  localparam int RW   = UW + 1;             // divider remainder
  localparam int KW   = $clog2(QW + 1);

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam longint T_LIM = 64 * ONE_L;
  localparam longint V_LIM = 32 * ONE_L;

  localparam logic [UW-1:0]        ONE_U  = UW'(ONE_L);
  localparam logic signed [TW-1:0] TEN_HI = TW'(ONE_L);
  localparam logic signed [TW-1:0] TEN_LO = TW'(-ONE_L);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_EVAL   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef struct packed {
    logic [UW-1:0]        x;
    logic [UW-1:0]        y;
    logic signed [TW-1:0] ten;
  } knot_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_RM_RD, S_RM_WR,
    S_EV_ONE, S_EV_SRD, S_EV_SCMP, S_EV_FET,
    S_DV_INIT, S_DV, S_DV_END,
    S_M0, S_M1, S_M2, S_MA, S_MU, S_MUT, S_MV, S_MVT, S_MR,
    S_DONE
  } state_t;

endpackage

// ----- src/tsenv_if.sv -----
`timescale 1ns / 1ps
// tsenv_in_if / tsenv_out_if: valid/ready channels of the envelope table
// depends on tsenv_pkg for widths

interface tsenv_in_if import tsenv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [UW-1:0]        phase;
  logic [UW-1:0]        new_x;
  logic [UW-1:0]        new_y;
  logic signed [TW-1:0] new_tension;
  logic [4:0]           remove_index;

  modport source (output valid, action, phase, new_x, new_y, new_tension, remove_index,
                  input ready);
  modport sink   (input valid, action, phase, new_x, new_y, new_tension, remove_index,
                  output ready);
endinterface

interface tsenv_out_if import tsenv_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [UW-1:0] level;
  logic [1:0]    status;
  logic [5:0]    points_held;

  modport source (output valid, level, status, points_held, input ready);
  modport sink   (input valid, level, status, points_held, output ready);
endinterface

// ----- src/tension_spline_envelope_table.sv -----
`timescale 1ns / 1ps
// tension_spline_envelope_table: sorted knot table with hermite evaluation
// depends on tsenv_pkg, tsenv_if (channels) and tsenv_ram (knot store)
//
//  channel | dir | words                                         | handshake
//  in_ch   | in  | action, phase, new_x, new_y, new_tension, idx | valid/ready
//  out_ch  | out | level, status, points_held                    | valid/ready
//
// one word at a time; steps from accept to result valid, n knots held:
//   insert moves each larger knot up by one, remove moves each knot above the index down
//   evaluate searches up to n-1 knots, then fetch, divide and multiply to the result,
//   divide skipped on a zero-width segment; full, refused and no-action words skip the walk
//   sync reset clears the knot count and handshake state; ram is not cleared
//   a result waits in the output register; the next word is taken meanwhile

module tension_spline_envelope_table import tsenv_pkg::*; #(
  parameter int POINT_CAPACITY = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  tsenv_in_if.sink    in_ch,
  tsenv_out_if.source out_ch
);

  localparam int IW = $clog2(POINT_CAPACITY);
  localparam int CW = $clog2(POINT_CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  // control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // knot store
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  knot_t         ram_wdata, rd;
  logic [$bits(knot_t)-1:0] ram_rdata;

  // latched word and walk indexes
  logic [UW-1:0]        nx_r, ny_r, ph_r;
  logic signed [TW-1:0] nt_r;
  logic [CW-1:0]        i_r, j_r, i1_r;
  logic [2:0]           f_r;

  // segment fetch
  logic [UW-1:0]        ym_r, x0_r, y0_r, x1_r, y1_r, y2_r;
  logic signed [TW-1:0] t0_r, t1_r;

  // divider
  logic [QW-1:0] q_r;
  logic [RW-1:0] rem_r;
  logic [UW-1:0] dv_r;
  logic [KW-1:0] k_r;
  logic          neg_r;

  // polynomial datapath
  logic signed [TQW-1:0] t_r;
  logic signed [PW-1:0]  p_r;
  logic signed [MTW-1:0] m0_r, m1_r;
  logic signed [UUW-1:0] u_r;
  logic signed [VW-1:0]  v_r;

  // result holding and output register
  logic [UW-1:0] res_level_r, out_level_r;
  logic [1:0]    res_status_r, out_status_r;
  logic [5:0]    out_points_r;

  // combinational helpers
  logic                 accept, full, rm_ok, ins_shift, ev_hit, advance;
  knot_t                new_knot;
  logic [CW-1:0]        im, i2, fetch_addr;
  logic signed [TW-1:0] dx, ph_d, dy0, dy2, dy01, clamp_t;
  logic [UW-1:0]        mag;
  logic [RW-1:0]        dv_sh, dv_sub;
  logic                 dv_ge;
  logic [QW-1:0]        t_mag;
  logic signed [TQW-1:0] t_pos;
  logic signed [SW-1:0] s2;
  logic signed [AW-1:0] a_v;
  logic signed [BW-1:0] b_v;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [SHW-1:0] p_sh, v_full, r_full;

  tsenv_ram #(
    .WIDTH ($bits(knot_t)),
    .DEPTH (POINT_CAPACITY)
  ) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = knot_t'(ram_rdata);
  assign accept   = in_ch.valid && (state_r == S_IDLE);
  assign in_ch.ready = (state_r == S_IDLE);
  assign full     = (cnt_r == CW'(POINT_CAPACITY));
  assign rm_ok    = (CMPW'(in_ch.remove_index) < CMPW'(cnt_r)) && (cnt_r > CW'(2));
  assign new_knot = '{x: nx_r, y: ny_r, ten: nt_r};
  assign ins_shift = (rd.x > nx_r);
  // first knot at or past the phase, or the last one
  assign ev_hit   = (ph_r <= rd.x) || (j_r == cnt_r - CW'(1));
  assign advance  = !out_valid_r || out_ch.ready;

  // neighbor knots for tangents, clipped at the table ends
  assign im = (i1_r != '0) ? i1_r - CW'(1) : i1_r;
  assign i2 = ((i1_r + CW'(2)) < cnt_r) ? i1_r + CW'(2) : i1_r + CW'(1);

  always_comb begin
    case (f_r)
      3'd0:    fetch_addr = im;
      3'd1:    fetch_addr = i1_r;
      3'd2:    fetch_addr = i1_r + CW'(1);
      default: fetch_addr = i2;
    endcase
  end

  // clamp of the incoming tension
  always_comb begin
    if (in_ch.new_tension > TEN_HI) begin
      clamp_t = TEN_HI;
    end else if (in_ch.new_tension < TEN_LO) begin
      clamp_t = TEN_LO;
    end else begin
      clamp_t = in_ch.new_tension;
    end
  end

  // segment parameter: (phase - x0) * one / (x1 - x0), magnitude then sign
  assign dx   = $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});
  assign ph_d = $signed({1'b0, ph_r}) - $signed({1'b0, x0_r});
  assign mag  = ph_d[TW-1] ? UW'(-ph_d) : UW'(ph_d);

  assign dv_sh  = {rem_r[RW-2:0], q_r[QW-1]};
  assign dv_ge  = (dv_sh >= {1'b0, dv_r});
  assign dv_sub = dv_sh - {1'b0, dv_r};

  assign t_mag = (q_r > QW'(T_LIM)) ? QW'(T_LIM) : q_r;
  assign t_pos = $signed(TQW'(t_mag));

  // hermite coefficients
  assign s2   = SW'(2 * ONE_L) - SW'(t0_r) - SW'(t1_r);
  assign dy0  = $signed({1'b0, y1_r}) - $signed({1'b0, ym_r});
  assign dy2  = $signed({1'b0, y2_r}) - $signed({1'b0, y0_r});
  assign dy01 = $signed({1'b0, y0_r}) - $signed({1'b0, y1_r});
  assign a_v  = (AW'(dy01) <<< 1) + AW'(m0_r) + AW'(m1_r);
  assign b_v  = -(BW'(dy01) <<< 1) - BW'(dy01) - (BW'(m0_r) <<< 1) - BW'(m1_r);

  // one shared multiplier, product registered in p_r
  assign prod   = mul_a * mul_b;
  assign p_sh   = SHW'(p_r >>> FRAC_BITS);
  assign v_full = p_sh + SHW'(m0_r);
  assign r_full = p_sh + SHW'($signed({1'b0, y0_r}));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = new_knot;
    ram_raddr     = '0;
    mul_a         = '0;
    mul_b         = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_ch.action))
            ACT_INSERT: state_nxt = full ? S_DONE : S_INS_RD;
            ACT_REMOVE: state_nxt = rm_ok ? S_RM_RD : S_DONE;
            ACT_EVAL: begin
              if (cnt_r == '0) begin
                state_nxt = S_DONE;
              end else if (cnt_r == CW'(1)) begin
                state_nxt = S_EV_ONE;
              end else begin
                state_nxt = S_EV_SRD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // walk down from the top, moving larger knots up by one
      S_INS_RD: begin
        if (i_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          ram_raddr = IW'(i_r - CW'(1));
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(i_r);
        if (ins_shift) begin
          ram_wdata = rd;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end
      // close the gap: move knots above the removed one down
      S_RM_RD: begin
        if (i_r == cnt_r - CW'(1)) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          ram_raddr = IW'(i_r + CW'(1));
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(i_r);
        ram_wdata = rd;
        state_nxt = S_RM_RD;
      end
      S_EV_ONE:  state_nxt = S_DONE;
      S_EV_SRD: begin
        ram_raddr = IW'(j_r);
        state_nxt = S_EV_SCMP;
      end
      S_EV_SCMP: state_nxt = ev_hit ? S_EV_FET : S_EV_SRD;
      S_EV_FET: begin
        ram_raddr = IW'(fetch_addr);
        if (f_r == 3'd4) begin
          state_nxt = S_DV_INIT;
        end
      end
      S_DV_INIT: state_nxt = (dx > 0) ? S_DV : S_M0;
      S_DV: begin
        if (k_r == KW'(1)) begin
          state_nxt = S_DV_END;
        end
      end
      S_DV_END:  state_nxt = S_M0;
      S_M0: begin
        mul_a     = MAW'(dy0);
        mul_b     = MBW'(s2);
        state_nxt = S_M1;
      end
      S_M1: begin
        mul_a     = MAW'(dy2);
        mul_b     = MBW'(s2);
        state_nxt = S_M2;
      end
      S_M2:      state_nxt = S_MA;
      S_MA: begin
        mul_a     = MAW'(a_v);
        mul_b     = t_r;
        state_nxt = S_MU;
      end
      S_MU:      state_nxt = S_MUT;
      S_MUT: begin
        mul_a     = u_r;
        mul_b     = t_r;
        state_nxt = S_MV;
      end
      S_MV:      state_nxt = S_MVT;
      S_MVT: begin
        mul_a     = MAW'(v_r);
        mul_b     = t_r;
        state_nxt = S_MR;
      end
      S_MR:      state_nxt = S_DONE;
      S_DONE: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          nx_r         <= (in_ch.new_x > ONE_U) ? ONE_U : in_ch.new_x;
          ny_r         <= (in_ch.new_y > ONE_U) ? ONE_U : in_ch.new_y;
          nt_r         <= clamp_t;
          ph_r         <= (in_ch.phase > ONE_U) ? ONE_U : in_ch.phase;
          j_r          <= CW'(1);
          res_level_r  <= '0;
          res_status_r <= ST_DONE;
          if (action_t'(in_ch.action) == ACT_INSERT) begin
            i_r <= cnt_r;
            if (full) begin
              res_status_r <= ST_FULL;
            end
          end else begin
            i_r <= CW'(in_ch.remove_index);
            if (action_t'(in_ch.action) == ACT_REMOVE && !rm_ok) begin
              res_status_r <= ST_REFUSED;
            end
          end
        end
      end
      S_INS_CMP: begin
        if (ins_shift) begin
          i_r <= i_r - CW'(1);
        end
      end
      S_RM_WR:   i_r <= i_r + CW'(1);
      S_EV_ONE:  res_level_r <= rd.y;
      S_EV_SCMP: begin
        if (ev_hit) begin
          i1_r <= j_r - CW'(1);
          f_r  <= '0;
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
      S_EV_FET: begin
        f_r <= f_r + 3'd1;
        case (f_r)
          3'd1: ym_r <= rd.y;
          3'd2: begin
            x0_r <= rd.x;
            y0_r <= rd.y;
            t0_r <= rd.ten;
          end
          3'd3: begin
            x1_r <= rd.x;
            y1_r <= rd.y;
            t1_r <= rd.ten;
          end
          3'd4: y2_r <= rd.y;
          default: ;
        endcase
      end
      S_DV_INIT: begin
        t_r   <= '0;
        neg_r <= ph_d[TW-1];
        q_r   <= {mag, {FRAC_BITS{1'b0}}};
        rem_r <= '0;
        dv_r  <= dx[UW-1:0];
        k_r   <= KW'(QW);
      end
      S_DV: begin
        rem_r <= dv_ge ? dv_sub : dv_sh;
        q_r   <= {q_r[QW-2:0], dv_ge};
        k_r   <= k_r - KW'(1);
      end
      S_DV_END: t_r <= neg_r ? -t_pos : t_pos;
      S_M0:  p_r <= prod;
      S_M1: begin
        m0_r <= MTW'(p_r >>> (FRAC_BITS + 1));
        p_r  <= prod;
      end
      S_M2:  m1_r <= MTW'(p_r >>> (FRAC_BITS + 1));
      S_MA:  p_r <= prod;
      S_MU:  u_r <= UUW'(p_sh + SHW'(b_v));
      S_MUT: p_r <= prod;
      S_MV: begin
        if (v_full > SHW'(V_LIM)) begin
          v_r <= VW'(V_LIM);
        end else if (v_full < SHW'(-V_LIM)) begin
          v_r <= VW'(-V_LIM);
        end else begin
          v_r <= VW'(v_full);
        end
      end
      S_MVT: p_r <= prod;
      S_MR: begin
        if (r_full < 0) begin
          res_level_r <= '0;
        end else if (r_full > SHW'(ONE_L)) begin
          res_level_r <= ONE_U;
        end else begin
          res_level_r <= UW'(r_full);
        end
      end
      S_DONE: begin
        if (advance) begin
          out_level_r  <= res_level_r;
          out_status_r <= res_status_r;
          out_points_r <= 6'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level       = out_level_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.points_held = out_points_r;

endmodule

// ----- src/tsenv_ram.sv -----
`timescale 1ns / 1ps
// tsenv_ram: generic single write port, single read port ram, registered read
// no dependencies

module tsenv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
